@@ src/rdsc_pkg.sv @@
// Shared types and constants of the datagram session controller.
package rdsc_pkg;

    typedef enum logic [3:0] {
        ACT_AUTH,
        ACT_JOIN,
        ACT_MESSAGE,
        ACT_TICK,
        ACT_CONFIRM,
        ACT_REPLY,
        ACT_MSG,
        ACT_ERR,
        ACT_BYE,
        ACT_UNKNOWN
    } t_action;

    typedef enum logic [2:0] {
        SEND_NONE,
        SEND_AUTH,
        SEND_JOIN,
        SEND_MSG,
        SEND_ACK,
        SEND_CLOSE,
        SEND_RESEND
    } t_send_kind;

    typedef enum logic [1:0] {
        REPLY_NONE,
        REPLY_OK,
        REPLY_FAIL
    } t_reply;

    typedef enum logic [2:0] {
        ST_OK,
        ST_WRONG_STATE,
        ST_BUSY,
        ST_ENDED,
        ST_TIMED_OUT,
        ST_PROTO_ERR,
        ST_ALREADY_ENDED
    } t_status;

    typedef enum logic [1:0] {
        SES_START,
        SES_AUTH,
        SES_OPEN
    } t_session;

    typedef struct packed {
        logic        reply_ok;
        logic [15:0] frame_id;
        t_action     action;
    } t_event;

    typedef struct packed {
        t_session    session_now;
        t_status     status;
        t_reply      reply_result;
        logic        deliver;
        logic [15:0] send_id;
        t_send_kind  send_kind;
    } t_result;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIES = 1'b1;

    localparam logic [15:0] TIMEOUT_RST = 16'd250;
    localparam logic [7:0]  RETRIES_RST = 8'd3;

endpackage

@@ src/rdsc_ctrl.sv @@
// Session state registers and the per-event decision logic.
module rdsc_ctrl
    import rdsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_event      i_event,
    input  logic [15:0] i_timeout,
    input  logic [7:0]  i_max_retries,
    output t_result     o_result
);

    t_session    r_session, n_session;
    logic        r_await, n_await;
    logic [7:0]  r_retry, n_retry;
    logic [15:0] r_tx, n_tx;
    logic        r_seen, n_seen;
    logic [15:0] r_last, n_last;
    logic [15:0] r_countdown, n_countdown;
    logic        r_ended, n_ended;

    logic [15:0] tx_prev;
    logic        reply_match;
    logic        msg_new;
    logic        expired_retry;

    assign tx_prev       = r_tx - 16'd1;
    assign reply_match   = (i_event.frame_id == tx_prev);
    assign msg_new       = !r_seen || (i_event.frame_id > r_last);
    assign expired_retry = (r_retry < i_max_retries);

    // next state
    always_comb begin
        n_session   = r_session;
        n_await     = r_await;
        n_retry     = r_retry;
        n_tx        = r_tx;
        n_seen      = r_seen;
        n_last      = r_last;
        n_countdown = r_countdown;
        n_ended     = r_ended;
        if (!r_ended) begin
            unique case (i_event.action) inside
                ACT_AUTH, ACT_JOIN, ACT_MESSAGE: begin
                    if (!r_await) begin
                        if (i_event.action == ACT_AUTH) begin
                            if (r_session != SES_OPEN) begin
                                n_session   = SES_AUTH;
                                n_await     = 1'b1;
                                n_countdown = i_timeout;
                            end
                        end else if (r_session == SES_OPEN) begin
                            n_await     = 1'b1;
                            n_countdown = i_timeout;
                        end
                    end
                end
                ACT_TICK: begin
                    if (r_await) begin
                        if (r_countdown > 16'd1) begin
                            n_countdown = r_countdown - 16'd1;
                        end else if (expired_retry) begin
                            n_retry     = r_retry + 8'd1;
                            n_countdown = i_timeout;
                        end else begin
                            n_ended = 1'b1;
                            n_await = 1'b0;
                        end
                    end
                end
                ACT_CONFIRM: begin
                    if (r_await && (i_event.frame_id == r_tx)) begin
                        n_await     = 1'b0;
                        n_tx        = r_tx + 16'd1;
                        n_retry     = '0;
                        n_countdown = i_timeout;
                    end
                end
                ACT_REPLY: begin
                    if (reply_match && i_event.reply_ok) begin
                        n_session = SES_OPEN;
                    end
                end
                ACT_MSG: begin
                    if (msg_new) begin
                        n_seen = 1'b1;
                        n_last = i_event.frame_id;
                    end
                end
                default: begin
                    n_ended = 1'b1;
                end
            endcase
        end
    end

    // result fields
    always_comb begin
        o_result              = '0;
        o_result.send_kind    = SEND_NONE;
        o_result.reply_result = REPLY_NONE;
        o_result.status       = ST_OK;
        o_result.session_now  = n_session;
        if (r_ended) begin
            o_result.status = ST_ALREADY_ENDED;
        end else begin
            unique case (i_event.action) inside
                ACT_AUTH, ACT_JOIN, ACT_MESSAGE: begin
                    if (r_await) begin
                        o_result.status = ST_BUSY;
                    end else if (i_event.action == ACT_AUTH) begin
                        if (r_session != SES_OPEN) begin
                            o_result.send_kind = SEND_AUTH;
                            o_result.send_id   = r_tx;
                        end else begin
                            o_result.status = ST_WRONG_STATE;
                        end
                    end else if (r_session == SES_OPEN) begin
                        o_result.send_kind = (i_event.action == ACT_JOIN) ? SEND_JOIN : SEND_MSG;
                        o_result.send_id   = r_tx;
                    end else begin
                        o_result.status = ST_WRONG_STATE;
                    end
                end
                ACT_TICK: begin
                    if (r_await && (r_countdown <= 16'd1)) begin
                        if (expired_retry) begin
                            o_result.send_kind = SEND_RESEND;
                            o_result.send_id   = r_tx;
                        end else begin
                            o_result.status = ST_TIMED_OUT;
                        end
                    end
                end
                ACT_CONFIRM: begin
                    o_result.status = ST_OK;
                end
                ACT_REPLY: begin
                    o_result.send_kind = SEND_ACK;
                    o_result.send_id   = i_event.frame_id;
                    if (reply_match) begin
                        o_result.reply_result = i_event.reply_ok ? REPLY_OK : REPLY_FAIL;
                    end
                end
                ACT_MSG: begin
                    o_result.send_kind = SEND_ACK;
                    o_result.send_id   = i_event.frame_id;
                    o_result.deliver   = msg_new;
                end
                ACT_ERR: begin
                    o_result.send_kind = SEND_ACK;
                    o_result.send_id   = i_event.frame_id;
                    o_result.status    = ST_ENDED;
                end
                ACT_BYE: begin
                    o_result.status = ST_ENDED;
                end
                default: begin
                    o_result.send_kind = SEND_CLOSE;
                    o_result.status    = ST_PROTO_ERR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session   <= SES_START;
            r_await     <= 1'b0;
            r_retry     <= '0;
            r_tx        <= '0;
            r_seen      <= 1'b0;
            r_last      <= '0;
            r_countdown <= '0;
            r_ended     <= 1'b0;
        end else if (i_step) begin
            r_session   <= n_session;
            r_await     <= n_await;
            r_retry     <= n_retry;
            r_tx        <= n_tx;
            r_seen      <= n_seen;
            r_last      <= n_last;
            r_countdown <= n_countdown;
            r_ended     <= n_ended;
        end
    end

endmodule

@@ src/reliable_datagram_session_control_core.sv @@
// Stop-and-wait session controller: one event in, one result out. Events are
// taken one per clock at full rate while the result port is not stalled; each
// request passes an input register and then the decision logic into the result
// register, from which its result is offered. The session state is updated as
// the request leaves the input register, so back-to-back events see each
// other's effects in order. Register writes are always ready. A new timeout
// applies at the next countdown load, a new retry limit at the next expiry.
module reliable_datagram_session_control_core
    import rdsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,  // frame_id[15:0], reply_ok[16], zero pad
    input  logic [3:0]           s_axis_tuser,  // action[3:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,  // send_id[15:0], deliver[16],
                                                // reply_result[18:17], status[21:19],
                                                // session_now[23:22]
    output logic [2:0]           m_axis_tuser,  // send_kind[2:0]
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic        r_in_valid;
    t_event      r_in;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_timeout;
    logic [7:0]  r_max_retries;

    t_result     result;
    logic        advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= TIMEOUT_RST;
            r_max_retries <= RETRIES_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT: r_timeout     <= i_cfg_data;
                CFG_RETRIES: r_max_retries <= i_cfg_data[7:0];
                default:     r_timeout     <= r_timeout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.action   <= t_action'(s_axis_tuser);
            r_in.frame_id <= s_axis_tdata[15:0];
            r_in.reply_ok <= s_axis_tdata[16];
        end
    end

    rdsc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_event       (r_in),
        .i_timeout     (r_timeout),
        .i_max_retries (r_max_retries),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.send_kind;
    assign m_axis_tdata  = {r_out.session_now, r_out.status, r_out.reply_result,
                            r_out.deliver, r_out.send_id};

`ifndef SYNTHESIS
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_idle_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.send_kind == SEND_NONE || r_out.send_kind == SEND_CLOSE)
        |-> r_out.send_id == 16'd0)
        else $error("nonzero id with no frame or bye");

    a_deliver_confirms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.deliver || r_out.reply_result != REPLY_NONE)
        |-> r_out.send_kind == SEND_ACK)
        else $error("delivered frame not confirmed");

    a_ended_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_ALREADY_ENDED
        |-> r_out.send_kind == SEND_NONE && !r_out.deliver)
        else $error("activity after session end");
`endif

endmodule
